// ===== rtl/xtea_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package xtea_pkg;

    localparam int unsigned XTEA_ROUNDS   = 32;
    localparam int unsigned NUM_KEY_WORDS = 4;
    localparam int unsigned KEY_SEL_W     = 2;
    localparam int unsigned WORD_W        = 32;
    localparam int unsigned CFG_ADDR_W    = 3;
    localparam logic [WORD_W-1:0] XTEA_DELTA = 32'h9E37_79B9;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } xtea_op_t;

    typedef logic [NUM_KEY_WORDS-1:0][WORD_W-1:0] key_set_t;

    typedef struct packed {
        xtea_op_t          op;
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
        logic              fin;
    } xtea_item_t;

    // Running sum seen by half-round STAGE; even stages come first in a round pair.
    function automatic logic [WORD_W-1:0] stage_sum(input int unsigned stage,
                                                    input logic dec,
                                                    input int unsigned rounds);
        int unsigned       pair;
        int unsigned       odd;
        logic [WORD_W-1:0] n;
        pair = stage >> 1;
        odd  = stage & 1;
        if (!dec) begin
            n = WORD_W'(pair + odd);
        end else begin
            n = WORD_W'(rounds - pair - odd);
        end
        return n * XTEA_DELTA;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/xtea_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xtea_stage #(
    parameter int unsigned ROUNDS = xtea_pkg::XTEA_ROUNDS,
    parameter int unsigned STAGE  = 0
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  en,
    input  wire                  in_valid,
    input  xtea_pkg::xtea_item_t in_item,
    input  xtea_pkg::key_set_t   keys,
    output logic                 out_valid,
    output xtea_pkg::xtea_item_t out_item
);
    import xtea_pkg::*;

    localparam logic [WORD_W-1:0] SUM_ENC = stage_sum(STAGE, 1'b0, ROUNDS);
    localparam logic [WORD_W-1:0] SUM_DEC = stage_sum(STAGE, 1'b1, ROUNDS);
    localparam logic              EVEN    = 1'((STAGE % 2) == 0);

    logic                 valid_reg;
    xtea_item_t           item_reg;
    xtea_item_t           item_next;
    logic                 dec;
    logic                 update_a;
    logic [WORD_W-1:0]    sum;
    logic [KEY_SEL_W-1:0] ksel;
    logic [WORD_W-1:0]    src;
    logic [WORD_W-1:0]    dst;
    logic [WORD_W-1:0]    mixv;
    logic [WORD_W-1:0]    tweak;
    logic [WORD_W-1:0]    res;

    // Encrypt: even stage updates word a, odd updates b; decrypt is the mirror.
    always_comb begin
        dec      = (in_item.op == OP_DECRYPT);
        update_a = EVEN ? !dec : dec;
        sum      = dec ? SUM_DEC : SUM_ENC;
        ksel     = update_a ? sum[1:0] : sum[12:11];
        src      = update_a ? in_item.word_b : in_item.word_a;
        dst      = update_a ? in_item.word_a : in_item.word_b;
        mixv     = ((src << 4) ^ (src >> 5)) + src;
        tweak    = mixv ^ (sum + keys[ksel]);
        res      = dec ? (dst - tweak) : (dst + tweak);
        item_next = in_item;
        if (update_a) begin
            item_next.word_a = res;
        end else begin
            item_next.word_b = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ===== rtl/xtea_block_cipher.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake               Payload
// s_axis    in   s_axis_tvalid/tready    tdata = block_low, block_high; tuser = opcode;
//                                        tlast = final_block
// m_axis    out  m_axis_tvalid/tready    tdata = out_low, out_high; tlast = out_final
// cfg       in   cfg_wr_en               cfg_addr = key word index, cfg_wr_data = key word
//
// One half-round per register stage, 2*ROUNDS stages, then an output register;
// one item is taken every cycle while the skid buffer is empty.
// The output register has a one-entry skid buffer; the pipeline stalls only while it is full.
// Synchronous active-low reset clears valid bits and sets all key words to zero.

module xtea_block_cipher #(
    parameter int unsigned ROUNDS = xtea_pkg::XTEA_ROUNDS
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire  [63:0]                      s_axis_tdata,  // block_low, block_high
    input  wire                              s_axis_tuser,  // opcode
    input  wire                              s_axis_tlast,
    output logic                             m_axis_tvalid,
    input  wire                              m_axis_tready,
    output logic [63:0]                      m_axis_tdata,  // out_low, out_high
    output logic                             m_axis_tlast,
    input  wire                              cfg_wr_en,
    input  wire  [xtea_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire  [xtea_pkg::WORD_W-1:0]      cfg_wr_data
);
    import xtea_pkg::*;

    localparam int unsigned STAGES = 2 * ROUNDS;

    key_set_t   key_reg;
    logic       pipe_en;
    logic       pipe_valid [0:STAGES];
    xtea_item_t pipe_item  [0:STAGES];
    logic       m_valid_reg;
    xtea_item_t m_item_reg;
    logic       skid_valid_reg;
    xtea_item_t skid_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else if (cfg_wr_en && (cfg_addr < CFG_ADDR_W'(NUM_KEY_WORDS))) begin
            key_reg[cfg_addr[KEY_SEL_W-1:0]] <= cfg_wr_data;
        end
    end

    assign pipe_en       = !skid_valid_reg;
    assign s_axis_tready = pipe_en;

    // op, word_a, word_b, fin from the top bit down
    assign pipe_valid[0] = s_axis_tvalid;
    assign pipe_item[0]  = {s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                            s_axis_tlast};

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        xtea_stage #(
            .ROUNDS (ROUNDS),
            .STAGE  (i)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_valid  (pipe_valid[i]),
            .in_item   (pipe_item[i]),
            .keys      (key_reg),
            .out_valid (pipe_valid[i+1]),
            .out_item  (pipe_item[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_axis_tready) begin
                m_item_reg     <= skid_item_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (pipe_valid[STAGES]) begin
            if (!m_valid_reg || m_axis_tready) begin
                m_valid_reg <= 1'b1;
                m_item_reg  <= pipe_item[STAGES];
            end else begin
                skid_valid_reg <= 1'b1;
                skid_item_reg  <= pipe_item[STAGES];
            end
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_item_reg.word_b, m_item_reg.word_a};
    assign m_axis_tlast  = m_item_reg.fin;

`ifndef ASSERT_OFF
    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid holds an item while output register is empty");

    a_skid_fill_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_axis_tready))
        else $error("skid filled while output was free");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !m_axis_tready |=> skid_valid_reg && $stable(skid_item_reg))
        else $error("skid item lost during stall");

    a_drain_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_valid[STAGES] && !skid_valid_reg |=> m_valid_reg)
        else $error("finished item did not reach output");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

import xtea_pkg::*;

class xtea_expectations;
    typedef struct packed {
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic              fin;
    } cipher_block_t;

    logic [WORD_W-1:0] key_word [NUM_KEY_WORDS];
    cipher_block_t     pending_blocks [$];
    int                errors;

    function new();
        foreach (key_word[i]) key_word[i] = '0;
        errors = 0;
    endfunction

    function void set_key(int unsigned idx, logic [WORD_W-1:0] value);
        if (idx < NUM_KEY_WORDS) begin
            key_word[idx] = value;
        end
    endfunction

    function logic [WORD_W-1:0] mix(logic [WORD_W-1:0] v);
        return ((v << 4) ^ (v >> 5)) + v;
    endfunction

    function cipher_block_t xtea_transform(xtea_op_t op, logic [WORD_W-1:0] lo,
                                           logic [WORD_W-1:0] hi, logic fin);
        cipher_block_t     res;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] s;
        a = lo;
        b = hi;
        if (op == OP_ENCRYPT) begin
            s = '0;
            for (int r = 0; r < XTEA_ROUNDS; r++) begin
                a = a + (mix(b) ^ (s + key_word[s[1:0]]));
                s = s + XTEA_DELTA;
                b = b + (mix(a) ^ (s + key_word[s[12:11]]));
            end
        end else begin
            s = WORD_W'(XTEA_ROUNDS) * XTEA_DELTA;
            for (int r = 0; r < XTEA_ROUNDS; r++) begin
                b = b - (mix(a) ^ (s + key_word[s[12:11]]));
                s = s - XTEA_DELTA;
                a = a - (mix(b) ^ (s + key_word[s[1:0]]));
            end
        end
        res.lo  = a;
        res.hi  = b;
        res.fin = fin;
        return res;
    endfunction

    function void note_block(xtea_op_t op, logic [WORD_W-1:0] lo,
                             logic [WORD_W-1:0] hi, logic fin);
        pending_blocks.push_back(xtea_transform(op, lo, hi, fin));
    endfunction

    function void check_block(logic [63:0] data, logic last);
        cipher_block_t exp_blk;
        if (pending_blocks.size() == 0) begin
            $display("%0t: unexpected item data=%h last=%b", $time, data, last);
            errors++;
            return;
        end
        exp_blk = pending_blocks.pop_front();
        if (data[31:0] !== exp_blk.lo) begin
            $display("%0t: out_low expected %h actual %h", $time, exp_blk.lo, data[31:0]);
            errors++;
        end
        if (data[63:32] !== exp_blk.hi) begin
            $display("%0t: out_high expected %h actual %h", $time, exp_blk.hi, data[63:32]);
            errors++;
        end
        if (last !== exp_blk.fin) begin
            $display("%0t: out_final expected %b actual %b", $time, exp_blk.fin, last);
            errors++;
        end
    endfunction

    function int pending();
        return pending_blocks.size();
    endfunction

    function void check_drained();
        if (pending_blocks.size() != 0) begin
            $display("%0t: %0d items never came out", $time, pending_blocks.size());
            errors++;
        end
    endfunction
endclass

module tb;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 2 * XTEA_ROUNDS + 8;
    localparam int NUM_PHASES     = 6;
    localparam int ITEMS_PER_PHASE = 318;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [63:0]           s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [63:0]           m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [WORD_W-1:0]     cfg_wr_data;

    xtea_expectations cipher_exp;
    int send_idle;
    int recv_stall;
    int quiet_cycles;

    xtea_block_cipher u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            cipher_exp.check_block(m_axis_tdata, m_axis_tlast);
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // cfg_wr_en is left high; the caller lowers it after the last write
    task write_reg(int unsigned idx, logic [WORD_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_ADDR_W'(idx);
        cfg_wr_data <= value;
        cipher_exp.set_key(idx, value);
        @(negedge aclk);
    endtask

    task send_block(xtea_op_t op, logic [WORD_W-1:0] lo, logic [WORD_W-1:0] hi, logic fin);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hi, lo};
        s_axis_tuser  <= op;
        s_axis_tlast  <= fin;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        cipher_exp.note_block(op, lo, hi, fin);
        @(negedge aclk);
    endtask

    task wait_drained();
        s_axis_tvalid <= 1'b0;
        while (cipher_exp.pending() != 0) @(negedge aclk);
    endtask

    function logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0] corner [5];
        corner = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1};
        if ($urandom_range(7) == 0) begin
            return corner[$urandom_range(4)];
        end
        return $urandom;
    endfunction

    initial begin
        logic [WORD_W-1:0] edge_lo [5];
        logic [WORD_W-1:0] edge_hi [5];
        logic [WORD_W-1:0] mixed_key [NUM_KEY_WORDS];
        int send_tab [4];
        int recv_tab [4];
        cipher_exp    = new();
        send_tab      = '{0, 55, 0, 16};
        recv_tab      = '{0, 0, 55, 16};
        edge_lo       = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h8000_0000};
        edge_hi       = '{32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001};
        mixed_key     = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001};
        send_idle     = 0;
        recv_stall    = 0;
        quiet_cycles  = 0;
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_ENCRYPT;
        s_axis_tlast  <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_addr      <= '0;
        cfg_wr_data   <= '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                for (int i = 0; i < NUM_KEY_WORDS; i++) begin
                    case (p)
                        1:       write_reg(i, 32'hFFFF_FFFF);
                        3:       write_reg(i, mixed_key[i]);
                        default: write_reg(i, $urandom);
                    endcase
                end
                // unmapped indexes must leave the key alone
                if (p == 4) begin
                    for (int i = NUM_KEY_WORDS; i < (1 << CFG_ADDR_W); i++) begin
                        write_reg(i, $urandom);
                    end
                end
                cfg_wr_en <= 1'b0;
                @(negedge aclk);
            end
            send_idle  = send_tab[p % 4];
            recv_stall = recv_tab[p % 4];

            if (p == 0) begin
                for (int i = 0; i < 5; i++) begin
                    send_block(OP_ENCRYPT, edge_lo[i], edge_hi[i], i[0]);
                    send_block(OP_DECRYPT, edge_lo[i], edge_hi[i], ~i[0]);
                end
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (p == 2 && n == ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                    @(negedge aclk);
                end
                send_block(xtea_op_t'($urandom_range(1)), pick_word(), pick_word(),
                           1'($urandom_range(1)));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cipher_exp.check_drained();
        if (cipher_exp.errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
